### src/positional_list_store_macros.svh
// ---------------------------------------------------------------------------
// Positional list store assertion macros
// Concurrent assertion shorthands used by the list store.
// ---------------------------------------------------------------------------
`ifndef POSITIONAL_LIST_STORE_MACROS_SVH
`define POSITIONAL_LIST_STORE_MACROS_SVH

// same-cycle implication
`define PLS_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define PLS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### src/pls_pkg.sv
// ---------------------------------------------------------------------------
// Positional list store package
// Request kinds, status codes and word types of the list store.
// ---------------------------------------------------------------------------
package pls_pkg;

   typedef logic signed [31:0] word_type;
   typedef logic [2:0]         kind_type;
   typedef logic [1:0]         status_type;

   localparam kind_type K_INS_FRONT = 3'd0;
   localparam kind_type K_INS_BACK  = 3'd1;
   localparam kind_type K_INS_AT    = 3'd2;
   localparam kind_type K_DEL_FRONT = 3'd3;
   localparam kind_type K_DEL_BACK  = 3'd4;
   localparam kind_type K_DEL_AT    = 3'd5;

   localparam status_type ST_DONE  = 2'd0;
   localparam status_type ST_EMPTY = 2'd1;
   localparam status_type ST_FULL  = 2'd2;
   localparam status_type ST_RANGE = 2'd3;

endpackage

### src/positional_list_store.sv
// ---------------------------------------------------------------------------
// Positional list store
// Ordered list of signed words with insert and delete at front, back or
// a given position; entries are moved one per cycle through a memory with
// one read and one write port.
// ---------------------------------------------------------------------------
// A request is taken only while the sequencer is idle and gives exactly one
// response word. Entries are shifted one per cycle through the entry memory
// (one read and one write a cycle, registered read data); an insert or a
// delete reads every entry from the target position to the end of the list,
// while appending at the back, rejected requests and unused codes read none.
// A finished response waits in its output register, so the next request can
// be accepted while it is stalled.
`include "positional_list_store_macros.svh"

module positional_list_store #(
   parameter int CAPACITY = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  pls_pkg::kind_type                  req_type,
   input  logic [$clog2(CAPACITY+1)-1:0]      req_position,
   input  pls_pkg::word_type                  req_value,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output pls_pkg::status_type                rsp_status,
   output pls_pkg::word_type                  rsp_removed_value,
   output logic [$clog2(CAPACITY+1)-1:0]      rsp_entry_count
);
   import pls_pkg::*;

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int AW = $clog2(CAPACITY);

   typedef logic [CW-1:0] cnt_type;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_RUN   = 3'd1;
   localparam logic [2:0] S_DRAIN = 3'd2;
   localparam logic [2:0] S_PUT   = 3'd3;
   localparam logic [2:0] S_DONE  = 3'd4;

   word_type entries_mem [CAPACITY];

   logic [2:0] state_ff, state_in;
   cnt_type    count_ff, count_in;
   cnt_type    pos_ff, pos_in;
   cnt_type    idx_ff, idx_in;
   cnt_type    rd_addr_ff;
   logic       ins_ff, ins_in;
   logic       rd_ok_ff;
   word_type   val_ff, val_in;
   word_type   rd_data_ff;
   word_type   removed_ff, removed_in;
   status_type status_ff, status_in;

   logic       rsp_valid_ff, rsp_valid_in;
   status_type rsp_status_ff, rsp_status_in;
   word_type   rsp_removed_ff, rsp_removed_in;
   cnt_type    rsp_count_ff, rsp_count_in;

   cnt_type    p_sel;
   logic       is_ins, is_del;
   status_type st_sel;
   logic       rd_en, last_rd;
   logic       mem_we;
   cnt_type    mem_wa;
   word_type   mem_wd;

   // request decode
   always_comb begin
      is_ins = 1'b0;
      is_del = 1'b0;
      p_sel  = '0;
      case (req_type)
         K_INS_FRONT: begin
            is_ins = 1'b1;
         end
         K_INS_BACK: begin
            is_ins = 1'b1;
            p_sel  = count_ff;
         end
         K_INS_AT: begin
            is_ins = 1'b1;
            p_sel  = req_position;
         end
         K_DEL_FRONT: begin
            is_del = 1'b1;
         end
         K_DEL_BACK: begin
            is_del = 1'b1;
            p_sel  = count_ff - CW'(1);
         end
         K_DEL_AT: begin
            is_del = 1'b1;
            p_sel  = req_position;
         end
         default: begin
            p_sel = '0;
         end
      endcase
      st_sel = ST_DONE;
      if (is_ins) begin
         if (count_ff == CW'(CAPACITY)) begin
            st_sel = ST_FULL;
         end else if (p_sel > count_ff) begin
            st_sel = ST_RANGE;
         end
      end else if (is_del) begin
         if (count_ff == '0) begin
            st_sel = ST_EMPTY;
         end else if (p_sel >= count_ff) begin
            st_sel = ST_RANGE;
         end
      end
   end

   assign last_rd = ins_ff ? (idx_ff == pos_ff) : (idx_ff == count_ff - CW'(1));

   // sequencer
   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      pos_in     = pos_ff;
      idx_in     = idx_ff;
      ins_in     = ins_ff;
      val_in     = val_ff;
      removed_in = removed_ff;
      status_in  = status_ff;
      rd_en      = 1'b0;
      mem_we     = 1'b0;
      mem_wa     = '0;
      mem_wd     = rd_data_ff;

      // move of the word read last cycle
      if (rd_ok_ff) begin
         if (ins_ff) begin
            mem_we = 1'b1;
            mem_wa = rd_addr_ff + CW'(1);
         end else if (rd_addr_ff != pos_ff) begin
            mem_we = 1'b1;
            mem_wa = rd_addr_ff - CW'(1);
         end else begin
            removed_in = rd_data_ff;
         end
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               ins_in     = is_ins;
               val_in     = req_value;
               pos_in     = p_sel;
               removed_in = '0;
               status_in  = st_sel;
               if (st_sel != ST_DONE || !(is_ins || is_del)) begin
                  state_in = S_DONE;
               end else if (is_ins && p_sel == count_ff) begin
                  state_in = S_PUT;
               end else begin
                  state_in = S_RUN;
                  idx_in   = is_ins ? count_ff - CW'(1) : p_sel;
               end
            end
         end
         S_RUN: begin
            rd_en = 1'b1;
            if (last_rd) begin
               state_in = S_DRAIN;
            end else begin
               idx_in = ins_ff ? idx_ff - CW'(1) : idx_ff + CW'(1);
            end
         end
         S_DRAIN: begin
            if (ins_ff) begin
               state_in = S_PUT;
            end else begin
               count_in = count_ff - CW'(1);
               state_in = S_DONE;
            end
         end
         S_PUT: begin
            mem_we   = 1'b1;
            mem_wa   = pos_ff;
            mem_wd   = val_ff;
            count_in = count_ff + CW'(1);
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // response register
   always_comb begin
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_status_in  = rsp_status_ff;
      rsp_removed_in = rsp_removed_ff;
      rsp_count_in   = rsp_count_ff;
      if (state_ff == S_DONE && (!rsp_valid_ff || !rsp_stall)) begin
         rsp_valid_in   = 1'b1;
         rsp_status_in  = status_ff;
         rsp_removed_in = removed_ff;
         rsp_count_in   = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rd_ok_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rd_ok_ff     <= rd_en;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff         <= pos_in;
      idx_ff         <= idx_in;
      ins_ff         <= ins_in;
      val_ff         <= val_in;
      removed_ff     <= removed_in;
      status_ff      <= status_in;
      rd_addr_ff     <= idx_ff;
      rsp_status_ff  <= rsp_status_in;
      rsp_removed_ff <= rsp_removed_in;
      rsp_count_ff   <= rsp_count_in;
   end

   // entry memory, one write and one registered read a cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         entries_mem[mem_wa[AW-1:0]] <= mem_wd;
      end
      if (rd_en) begin
         rd_data_ff <= entries_mem[idx_ff[AW-1:0]];
      end
   end

   assign req_stall         = (state_ff != S_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_removed_value = rsp_removed_ff;
   assign rsp_entry_count   = rsp_count_ff;

   `PLS_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= CW'(CAPACITY), "count above capacity")
   `PLS_ASSERT_NEXT(a_idle_count_held, clock, reset, state_ff == S_IDLE, count_ff == $past(count_ff), "count moved while idle")
   `PLS_ASSERT_NOW(a_failed_no_word, clock, reset, rsp_valid && rsp_status != ST_DONE, rsp_removed_value == '0, "removed word on failed request")
   `PLS_ASSERT_NOW(a_read_in_move, clock, reset, rd_ok_ff, state_ff == S_RUN || state_ff == S_DRAIN, "stray read data")

endmodule

### bench/tb_top.sv
// ---------------------------------------------------------------------------
// Positional list store testbench
// Walks a directed table of list commands (empty, full, range errors,
// spare codes, extreme values), then about 1200 random commands that
// swing the list between empty and full. Every response word is checked
// against the table's reply or a shadow copy of the list kept in the bench.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
   import pls_pkg::*;

   localparam int CAP = 16;
   localparam int N_RANDOM = 1200;
   localparam kind_type K_SPARE_A = 3'd6;
   localparam kind_type K_SPARE_B = 3'd7;

   typedef struct {
      status_type status;
      word_type   removed;
      logic [4:0] count;
   } list_reply_type;

   typedef struct packed {
      kind_type   kind;
      logic [4:0] pos;
      word_type   value;
      logic [4:0] reps;
      logic       typed;
      status_type st;
      word_type   removed;
      logic [4:0] count;
   } cmd_row_type;

   logic       clock = 1'b0;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   kind_type   req_type;
   logic [4:0] req_position;
   word_type   req_value;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   status_type rsp_status;
   word_type   rsp_removed_value;
   logic [4:0] rsp_entry_count;

   word_type       shadow_list [CAP];
   int             shadow_len;
   list_reply_type pending_replies [$];
   list_reply_type head_word;
   int             fails;
   bit             quiet;
   bit             filling;
   cmd_row_type    plan [25];

   positional_list_store #(.CAPACITY(CAP)) dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_type          (req_type),
      .req_position      (req_position),
      .req_value         (req_value),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_removed_value (rsp_removed_value),
      .rsp_entry_count   (rsp_entry_count)
   );

   always #5 clock = ~clock;

   // shadow list: applies one command and gives the reply it should produce
   function automatic list_reply_type apply_list_op(kind_type k, logic [4:0] p, word_type v);
      list_reply_type r;
      int at;
      int i;
      r.status  = ST_DONE;
      r.removed = '0;
      case (k)
         K_INS_FRONT, K_INS_BACK, K_INS_AT: begin
            if (k == K_INS_FRONT) at = 0;
            else if (k == K_INS_BACK) at = shadow_len;
            else at = int'(p);
            if (shadow_len >= CAP) begin
               r.status = ST_FULL;
            end else if (at > shadow_len) begin
               r.status = ST_RANGE;
            end else begin
               for (i = shadow_len; i > at; i--) shadow_list[i] = shadow_list[i-1];
               shadow_list[at] = v;
               shadow_len++;
            end
         end
         K_DEL_FRONT, K_DEL_BACK, K_DEL_AT: begin
            if (k == K_DEL_FRONT) at = 0;
            else if (k == K_DEL_BACK) at = (shadow_len == 0) ? 0 : shadow_len - 1;
            else at = int'(p);
            if (shadow_len == 0) begin
               r.status = ST_EMPTY;
            end else if (at >= shadow_len) begin
               r.status = ST_RANGE;
            end else begin
               r.removed = shadow_list[at];
               for (i = at; i + 1 < shadow_len; i++) shadow_list[i] = shadow_list[i+1];
               shadow_len--;
            end
         end
         default: ;
      endcase
      r.count = 5'(shadow_len);
      return r;
   endfunction

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic send_word(kind_type k, logic [4:0] p, word_type v, bit typed,
                            list_reply_type typed_reply);
      list_reply_type predicted;
      while (!quiet && $urandom_range(99) < 21) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_type     <= k;
      req_position <= p;
      req_value    <= v;
      predicted = apply_list_op(k, p, v);
      pending_replies.push_back(typed ? typed_reply : predicted);
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic drain_replies();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending_replies.size() != 0) @(negedge clock);
   endtask

   task automatic pick_random(output kind_type k, output logic [4:0] p, output word_type v);
      int r;
      r = $urandom_range(99);
      if (shadow_len == CAP && $urandom_range(3) == 0) filling = 1'b0;
      if (shadow_len == 0 && $urandom_range(3) == 0) filling = 1'b1;
      if (r < 3) begin
         k = $urandom_range(1) ? K_SPARE_A : K_SPARE_B;
      end else if ($urandom_range(99) < (filling ? 75 : 25)) begin
         case ($urandom_range(3))
            0: k = K_INS_FRONT;
            1: k = K_INS_BACK;
            default: k = K_INS_AT;
         endcase
      end else begin
         case ($urandom_range(3))
            0: k = K_DEL_FRONT;
            1: k = K_DEL_BACK;
            default: k = K_DEL_AT;
         endcase
      end
      p = 5'($urandom_range(31));
      if ($urandom_range(99) < 85) begin
         if (k == K_INS_AT) p = 5'($urandom_range(shadow_len));
         else if (k == K_DEL_AT) p = 5'($urandom_range(shadow_len == 0 ? 0 : shadow_len - 1));
      end
      case ($urandom_range(19))
         0: v = 32'h8000_0000;
         1: v = 32'h7fff_ffff;
         2: v = '0;
         3: v = '1;
         default: v = word_type'($urandom);
      endcase
   endtask

   initial begin
      kind_type       k;
      logic [4:0]     p;
      word_type       v;
      list_reply_type typed_reply;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_type     = K_INS_FRONT;
      req_position = '0;
      req_value    = '0;
      shadow_len   = 0;
      fails        = 0;
      quiet        = 1'b0;
      filling      = 1'b1;
      plan = '{
         '{K_DEL_FRONT, 5'd0,  32'h0000_0000, 5'd1,  1'b1, ST_EMPTY, 32'h0, 5'd0},
         '{K_DEL_BACK,  5'd9,  32'h0000_0001, 5'd1,  1'b1, ST_EMPTY, 32'h0, 5'd0},
         '{K_DEL_AT,    5'd0,  32'h0000_0000, 5'd1,  1'b1, ST_EMPTY, 32'h0, 5'd0},
         '{K_INS_AT,    5'd1,  32'h1111_1111, 5'd1,  1'b1, ST_RANGE, 32'h0, 5'd0},
         '{K_INS_AT,    5'd0,  32'h7fff_ffff, 5'd1,  1'b1, ST_DONE,  32'h0, 5'd1},
         '{K_INS_BACK,  5'd0,  32'h8000_0000, 5'd1,  1'b1, ST_DONE,  32'h0, 5'd2},
         '{K_INS_FRONT, 5'd31, 32'hffff_ffff, 5'd1,  1'b1, ST_DONE,  32'h0, 5'd3},
         '{K_SPARE_A,   5'd31, 32'ha5a5_a5a5, 5'd1,  1'b1, ST_DONE,  32'h0, 5'd3},
         '{K_SPARE_B,   5'd16, 32'h5a5a_5a5a, 5'd1,  1'b1, ST_DONE,  32'h0, 5'd3},
         '{K_DEL_AT,    5'd3,  32'h0000_0000, 5'd1,  1'b1, ST_RANGE, 32'h0, 5'd3},
         '{K_DEL_AT,    5'd31, 32'h0000_0000, 5'd1,  1'b1, ST_RANGE, 32'h0, 5'd3},
         '{K_INS_AT,    5'd4,  32'h0000_0001, 5'd1,  1'b1, ST_RANGE, 32'h0, 5'd3},
         '{K_INS_AT,    5'd3,  32'h1234_5678, 5'd1,  1'b1, ST_DONE,  32'h0, 5'd4},
         '{K_DEL_AT,    5'd1,  32'h0000_0000, 5'd1,  1'b1, ST_DONE,  32'h7fff_ffff, 5'd3},
         '{K_INS_AT,    5'd1,  32'h0001_0000, 5'd13, 1'b0, ST_DONE,  32'h0, 5'd0},
         '{K_INS_FRONT, 5'd0,  32'h0bad_0001, 5'd1,  1'b1, ST_FULL,  32'h0, 5'd16},
         '{K_INS_AT,    5'd16, 32'h0bad_0002, 5'd1,  1'b1, ST_FULL,  32'h0, 5'd16},
         '{K_INS_AT,    5'd31, 32'h0bad_0003, 5'd1,  1'b1, ST_FULL,  32'h0, 5'd16},
         '{K_INS_BACK,  5'd0,  32'h0bad_0004, 5'd1,  1'b1, ST_FULL,  32'h0, 5'd16},
         '{K_DEL_AT,    5'd16, 32'h0000_0000, 5'd1,  1'b1, ST_RANGE, 32'h0, 5'd16},
         '{K_DEL_AT,    5'd15, 32'h0000_0000, 5'd1,  1'b0, ST_DONE,  32'h0, 5'd0},
         '{K_DEL_BACK,  5'd0,  32'h0000_0000, 5'd1,  1'b0, ST_DONE,  32'h0, 5'd0},
         '{K_DEL_AT,    5'd7,  32'h0000_0000, 5'd1,  1'b0, ST_DONE,  32'h0, 5'd0},
         '{K_DEL_FRONT, 5'd0,  32'h0000_0000, 5'd13, 1'b0, ST_DONE,  32'h0, 5'd0},
         '{K_DEL_BACK,  5'd0,  32'h0000_0000, 5'd1,  1'b1, ST_EMPTY, 32'h0, 5'd0}
      };
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (plan[r]) begin
         typed_reply.status  = plan[r].st;
         typed_reply.removed = plan[r].removed;
         typed_reply.count   = plan[r].count;
         for (int n = 0; n < int'(plan[r].reps); n++)
            send_word(plan[r].kind, plan[r].pos, plan[r].value + word_type'(n),
                      plan[r].typed, typed_reply);
      end
      drain_replies();

      for (int n = 0; n < N_RANDOM; n++) begin
         quiet = (n >= 500 && n < 700);
         if (n == 300) drain_replies();
         pick_random(k, p, v);
         send_word(k, p, v, 1'b0, typed_reply);
      end
      quiet = 1'b0;

      req_valid <= 1'b0;
      while (pending_replies.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);
      if (fails == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   always @(negedge clock) begin
      rsp_stall <= !quiet && ($urandom_range(99) < 21);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_replies.size() == 0) begin
            $error("response word with nothing outstanding");
            fails++;
         end else begin
            head_word = pending_replies.pop_front();
            if (rsp_status !== head_word.status) begin
               $error("status: expected %0d, got %0d", head_word.status, rsp_status);
               fails++;
            end
            if (rsp_removed_value !== head_word.removed) begin
               $error("removed_value: expected %0d, got %0d", head_word.removed,
                      rsp_removed_value);
               fails++;
            end
            if (rsp_entry_count !== head_word.count) begin
               $error("entry_count: expected %0d, got %0d", head_word.count,
                      rsp_entry_count);
               fails++;
            end
         end
      end
   end

   initial begin
      #2_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
